// File: sv/uvs_pkg.sv
// Shared types, constants and tables of the UV sphere vertex generator.
`default_nettype none
package uvs_pkg;

    localparam int INDEX_WIDTH  = 10;
    localparam int CORDIC_STEPS = 16;

    localparam int RAD_W  = 31;
    localparam int VIDX_W = 20;
    localparam int TEX_W  = 17;
    localparam int POS_W  = 32;
    localparam int NORM_W = 16;
    localparam int ANG_W  = 33;     // angle in Q30, up to 2*pi
    localparam int CW     = 34;     // CORDIC datapath width
    localparam int TRIG_W = 32;     // sine / cosine in Q30
    localparam int OUT_W  = 224;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned K_Q30       = 64'd652032874;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RING    = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    // per-item sideband that rides along the divider
    typedef struct packed {
        t_status             status;
        logic [VIDX_W-1:0]   vidx;
        logic [VIDX_W-1:0]   second;
        logic                faces;
    } t_side;

    // sideband that rides along the CORDIC and the multipliers
    typedef struct packed {
        t_side              side;
        logic [TEX_W-1:0]   tex_u;
        logic [TEX_W-1:0]   tex_v;
    } t_side2;

endpackage
`default_nettype wire

// File: sv/uvs_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
`default_nettype none
module uvs_div #(
    parameter int IW    = uvs_pkg::INDEX_WIDTH,
    parameter int NUM_W = uvs_pkg::INDEX_WIDTH + 34,
    parameter int QUO_W = uvs_pkg::ANG_W,
    parameter int LANES = 4,
    parameter int TAG_W = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [NUM_W-1:0]   i_num [LANES],
    input  wire logic [IW-1:0]      i_div [LANES],
    input  wire logic [TAG_W-1:0]   i_tag,
    output logic                    o_valid,
    output logic [QUO_W-1:0]        o_quo [LANES],
    output logic [TAG_W-1:0]        o_tag
);

    logic             r_v   [QUO_W];
    logic [TAG_W-1:0] r_t   [QUO_W];
    logic [IW-1:0]    r_rem [QUO_W][LANES];
    logic [QUO_W-1:0] r_num [QUO_W][LANES];
    logic [QUO_W-1:0] r_quo [QUO_W][LANES];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic             w_v;
        logic [TAG_W-1:0] w_t;
        logic [IW-1:0]    w_rem [LANES];
        logic [QUO_W-1:0] w_num [LANES];
        logic [QUO_W-1:0] w_quo [LANES];

        if (s == 0) begin : g_first
            assign w_v = i_valid;
            assign w_t = i_tag;
            for (genvar l = 0; l < LANES; l++) begin : g_in
                // upper numerator bits are below the divisor for in-range items
                assign w_rem[l] = i_num[l][QUO_W+IW-1:QUO_W];
                assign w_num[l] = i_num[l][QUO_W-1:0];
                assign w_quo[l] = '0;
            end
        end else begin : g_next
            assign w_v = r_v[s-1];
            assign w_t = r_t[s-1];
            for (genvar l = 0; l < LANES; l++) begin : g_in
                assign w_rem[l] = r_rem[s-1][l];
                assign w_num[l] = r_num[s-1][l];
                assign w_quo[l] = r_quo[s-1][l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[s] <= w_t;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [IW:0] w_trial;
            logic [IW:0] w_diff;
            logic        w_ge;
            assign w_trial = {w_rem[l], w_num[l][QUO_W-1]};
            assign w_diff  = w_trial - {1'b0, i_div[l]};
            assign w_ge    = (w_trial >= {1'b0, i_div[l]});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s][l] <= w_ge ? w_diff[IW-1:0] : w_trial[IW-1:0];
                    r_num[s][l] <= {w_num[l][QUO_W-2:0], 1'b0};
                    r_quo[s][l] <= {w_quo[l][QUO_W-2:0], w_ge};
                end
            end
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_tag   = r_t[QUO_W-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_quo[l] = r_quo[QUO_W-1][l];
    end

endmodule
`default_nettype wire

// File: sv/uvs_cordic.sv
// Pipelined rotation-mode CORDIC sine/cosine with quadrant folding.
`default_nettype none
module uvs_cordic #(
    parameter int STEPS = uvs_pkg::CORDIC_STEPS,
    parameter int LANES = 2,
    parameter int TAG_W = 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [uvs_pkg::ANG_W-1:0]         i_ang [LANES],
    input  wire logic [TAG_W-1:0]                  i_tag,
    output logic                                   o_valid,
    output logic signed [uvs_pkg::TRIG_W-1:0]      o_sin [LANES],
    output logic signed [uvs_pkg::TRIG_W-1:0]      o_cos [LANES],
    output logic [TAG_W-1:0]                       o_tag
);

    localparam int AW = uvs_pkg::ANG_W;
    localparam int CW = uvs_pkg::CW;
    localparam int TW = uvs_pkg::TRIG_W;
    localparam logic [AW-1:0] H1 = AW'(uvs_pkg::HALF_PI_Q30);
    localparam logic [AW-1:0] H2 = AW'(2 * uvs_pkg::HALF_PI_Q30);
    localparam logic [AW-1:0] H3 = AW'(3 * uvs_pkg::HALF_PI_Q30);
    localparam logic [AW-1:0] H4 = AW'(4 * uvs_pkg::HALF_PI_Q30);
    localparam logic signed [CW-1:0] K_INIT = CW'(uvs_pkg::K_Q30);
    localparam logic signed [CW-1:0] ONE    = CW'(uvs_pkg::ONE_Q30);

    logic                   r_v [STEPS+1];
    logic [TAG_W-1:0]       r_t [STEPS+1];
    logic [1:0]             r_q [STEPS+1][LANES];
    logic signed [CW-1:0]   r_x [STEPS+1][LANES];
    logic signed [CW-1:0]   r_y [STEPS+1][LANES];
    logic signed [CW-1:0]   r_z [STEPS+1][LANES];

    logic                   r_fv;
    logic [TAG_W-1:0]       r_ft;
    logic signed [TW-1:0]   r_sin [LANES];
    logic signed [TW-1:0]   r_cos [LANES];

    // quadrant split: compare against multiples of pi/2
    for (genvar l = 0; l < LANES; l++) begin : g_quad
        logic [1:0]    w_q;
        logic [AW-1:0] w_rem;
        always_comb begin
            if (i_ang[l] >= H4) begin
                w_q = 2'd0; w_rem = i_ang[l] - H4;
            end else if (i_ang[l] >= H3) begin
                w_q = 2'd3; w_rem = i_ang[l] - H3;
            end else if (i_ang[l] >= H2) begin
                w_q = 2'd2; w_rem = i_ang[l] - H2;
            end else if (i_ang[l] >= H1) begin
                w_q = 2'd1; w_rem = i_ang[l] - H1;
            end else begin
                w_q = 2'd0; w_rem = i_ang[l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[0][l] <= w_q;
                r_x[0][l] <= K_INIT;
                r_y[0][l] <= '0;
                r_z[0][l] <= $signed(CW'(w_rem));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0] <= i_tag;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_iter
        localparam logic signed [CW-1:0] ATAN = CW'(uvs_pkg::ATAN_Q30[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[k+1] <= r_t[k];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[k+1][l] <= r_q[k][l];
                    if (!r_z[k][l][CW-1]) begin
                        r_x[k+1][l] <= r_x[k][l] - (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] + (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] - ATAN;
                    end else begin
                        r_x[k+1][l] <= r_x[k][l] + (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] - (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] + ATAN;
                    end
                end
            end
        end
    end

    // clamp to +-1.0 and unfold the quadrant
    for (genvar l = 0; l < LANES; l++) begin : g_fold
        logic signed [CW-1:0] w_xc;
        logic signed [CW-1:0] w_yc;
        logic signed [TW-1:0] w_x;
        logic signed [TW-1:0] w_y;
        always_comb begin
            w_xc = r_x[STEPS][l];
            w_yc = r_y[STEPS][l];
            if (w_xc > ONE) begin
                w_xc = ONE;
            end else if (w_xc < -ONE) begin
                w_xc = -ONE;
            end
            if (w_yc > ONE) begin
                w_yc = ONE;
            end else if (w_yc < -ONE) begin
                w_yc = -ONE;
            end
            w_x = TW'(w_xc);
            w_y = TW'(w_yc);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                case (r_q[STEPS][l])
                    2'd0: begin r_cos[l] <= w_x;  r_sin[l] <= w_y;  end
                    2'd1: begin r_cos[l] <= -w_y; r_sin[l] <= w_x;  end
                    2'd2: begin r_cos[l] <= -w_x; r_sin[l] <= -w_y; end
                    default: begin r_cos[l] <= w_y; r_sin[l] <= -w_x; end
                endcase
            end
        end

        assign o_sin[l] = r_sin[l];
        assign o_cos[l] = r_cos[l];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_en) begin
            r_fv <= r_v[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ft <= r_t[STEPS];
        end
    end

    assign o_valid = r_fv;
    assign o_tag   = r_ft;

endmodule
`default_nettype wire

// File: sv/uv_sphere_vertex_generator_core.sv
// Top level of the UV sphere vertex generator: config registers, index math, trig and scaling.
// Takes one (ring, segment) index pair per clock and returns one vertex per item in order.
// The pipeline has one input stage, 33 divider stages (one angle bit each), CORDIC_STEPS + 2
// CORDIC stages, two multiply stages and the output register. The whole pipeline advances
// together; it holds only while a result waits on m_axis with m_axis_tready low.
// Configuration may only be written while no item is in flight.
`default_nettype none
module uv_sphere_vertex_generator_core #(
    parameter int INDEX_WIDTH  = uvs_pkg::INDEX_WIDTH,
    parameter int CORDIC_STEPS = uvs_pkg::CORDIC_STEPS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [uvs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [uvs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // ring_index, segment_index
    input  wire logic [((2*INDEX_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // status, vertex_index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
    // tex_u, tex_v, has_faces, second_index
    output logic [uvs_pkg::OUT_W-1:0]               m_axis_tdata
);

    localparam int IW     = INDEX_WIDTH;
    localparam int NUM_W  = IW + 34;
    localparam int QUO_W  = uvs_pkg::ANG_W;
    localparam int PW     = 2 * IW + 2;
    localparam int VW     = uvs_pkg::VIDX_W;
    localparam int TXW    = uvs_pkg::TEX_W;
    localparam int TW     = uvs_pkg::TRIG_W;
    localparam int NW     = uvs_pkg::NORM_W;
    localparam int PSW    = uvs_pkg::POS_W;
    localparam int SIDE_W = $bits(uvs_pkg::t_side);
    localparam int SIDE2_W = $bits(uvs_pkg::t_side2);

    logic                          w_en;
    logic [uvs_pkg::RAD_W-1:0]     r_radius;
    logic [IW-1:0]                 r_seg;
    logic [IW-1:0]                 r_rng;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= uvs_pkg::RAD_W'(65536);
            r_seg    <= IW'(32);
            r_rng    <= IW'(16);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                uvs_pkg::REG_RADIUS:  r_radius <= i_cfg_data[uvs_pkg::RAD_W-1:0];
                uvs_pkg::REG_SEGMENT: r_seg    <= i_cfg_data[IW-1:0];
                uvs_pkg::REG_RING:    r_rng    <= i_cfg_data[IW-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless the output item is held
    logic r_out_valid;
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // ---------------- stage 1: index math and numerators ----------------
    logic [IW-1:0]      w_i;
    logic [IW-1:0]      w_j;
    logic [PW-1:0]      w_vfull;
    uvs_pkg::t_side     w_side;
    logic [NUM_W-1:0]   w_num [4];

    assign w_i     = s_axis_tdata[IW-1:0];
    assign w_j     = s_axis_tdata[2*IW-1:IW];
    assign w_vfull = PW'(w_i) * PW'(r_seg) + PW'(w_i) + PW'(w_j);

    always_comb begin
        if (r_radius == '0 || r_seg == '0 || r_rng == '0) begin
            w_side.status = uvs_pkg::ST_EMPTY;
        end else if (w_i > r_rng || w_j > r_seg) begin
            w_side.status = uvs_pkg::ST_RANGE;
        end else begin
            w_side.status = uvs_pkg::ST_OK;
        end
        w_side.vidx   = VW'(w_vfull);
        w_side.second = VW'(w_vfull) + VW'(r_seg) + VW'(1);
        w_side.faces  = (w_i < r_rng) && (w_j < r_seg);
    end

    // rounded divisions: angle theta, angle phi, tex u, tex v
    assign w_num[0] = NUM_W'(w_i) * NUM_W'(uvs_pkg::PI_Q30) + NUM_W'(r_rng >> 1);
    assign w_num[1] = NUM_W'(w_j) * NUM_W'(uvs_pkg::TWO_PI_Q30) + NUM_W'(r_seg >> 1);
    assign w_num[2] = NUM_W'({w_j, 16'b0}) + NUM_W'(r_seg >> 1);
    assign w_num[3] = NUM_W'({w_i, 16'b0}) + NUM_W'(r_rng >> 1);

    logic               r1_valid;
    uvs_pkg::t_side     r1_side;
    logic [NUM_W-1:0]   r1_num [4];
    logic [IW-1:0]      w_div [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_side <= w_side;
            r1_num  <= w_num;
        end
    end

    assign w_div[0] = r_rng;
    assign w_div[1] = r_seg;
    assign w_div[2] = r_seg;
    assign w_div[3] = r_rng;

    // ---------------- divider ----------------
    logic                d_valid;
    logic [QUO_W-1:0]    d_quo [4];
    logic [SIDE_W-1:0]   d_tag;
    uvs_pkg::t_side      d_side;

    uvs_div #(
        .IW    (IW),
        .NUM_W (NUM_W),
        .QUO_W (QUO_W),
        .LANES (4),
        .TAG_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_valid),
        .i_num   (r1_num),
        .i_div   (w_div),
        .i_tag   (r1_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_tag   (d_tag)
    );

    assign d_side = d_tag;

    // ---------------- CORDIC ----------------
    uvs_pkg::t_side2         c_in_tag;
    logic [QUO_W-1:0]        c_ang [2];
    logic                    c_valid;
    logic signed [TW-1:0]    c_sin [2];
    logic signed [TW-1:0]    c_cos [2];
    logic [SIDE2_W-1:0]      c_tag;

    assign c_in_tag.side  = d_side;
    assign c_in_tag.tex_u = TXW'(d_quo[2]);
    assign c_in_tag.tex_v = TXW'(d_quo[3]);
    assign c_ang[0]       = d_quo[0];
    assign c_ang[1]       = d_quo[1];

    uvs_cordic #(
        .STEPS (CORDIC_STEPS),
        .LANES (2),
        .TAG_W (SIDE2_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (d_valid),
        .i_ang   (c_ang),
        .i_tag   (c_in_tag),
        .o_valid (c_valid),
        .o_sin   (c_sin),
        .o_cos   (c_cos),
        .o_tag   (c_tag)
    );

    // ---------------- M1: sin theta times cos/sin phi ----------------
    logic                   r2_valid;
    uvs_pkg::t_side2        r2_tag;
    logic signed [63:0]     r2_px;
    logic signed [63:0]     r2_pz;
    logic signed [TW-1:0]   r2_uy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_tag <= c_tag;
            r2_px  <= 64'(c_sin[0]) * 64'(c_cos[1]);
            r2_pz  <= 64'(c_sin[0]) * 64'(c_sin[1]);
            r2_uy  <= c_cos[0];
        end
    end

    // ---------------- M2: round to Q30, normals, radius products ----------------
    logic signed [63:0]     w_pxr;
    logic signed [63:0]     w_pzr;
    logic signed [TW-1:0]   w_u [3];
    logic signed [TW-1:0]   w_nr [3];
    logic signed [NW-1:0]   w_norm [3];
    logic signed [63:0]     w_rad;

    assign w_pxr  = (r2_px + 64'sd536870912) >>> 30;
    assign w_pzr  = (r2_pz + 64'sd536870912) >>> 30;
    assign w_u[0] = TW'(w_pxr);
    assign w_u[1] = r2_uy;
    assign w_u[2] = TW'(w_pzr);
    assign w_rad  = $signed(64'(r_radius));

    for (genvar a = 0; a < 3; a++) begin : g_norm
        assign w_nr[a] = (w_u[a] + TW'(16384)) >>> 15;
        always_comb begin
            if (w_nr[a] > TW'(32767)) begin
                w_norm[a] = NW'(32767);
            end else if (w_nr[a] < -TW'(32767)) begin
                w_norm[a] = -NW'(32767);
            end else begin
                w_norm[a] = NW'(w_nr[a]);
            end
        end
    end

    logic                   r3_valid;
    uvs_pkg::t_side2        r3_tag;
    logic signed [63:0]     r3_pp [3];
    logic signed [NW-1:0]   r3_norm [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_tag <= r2_tag;
            for (int a = 0; a < 3; a++) begin
                r3_pp[a]   <= w_rad * 64'(w_u[a]);
                r3_norm[a] <= w_norm[a];
            end
        end
    end

    // ---------------- M3: position rounding and output register ----------------
    logic signed [63:0]     w_pr [3];
    logic signed [PSW-1:0]  w_pos [3];
    logic                   w_ok;

    for (genvar a = 0; a < 3; a++) begin : g_pos
        assign w_pr[a] = (r3_pp[a] + 64'sd536870912) >>> 30;
        always_comb begin
            if (w_pr[a] > 64'sd2147483647) begin
                w_pos[a] = PSW'(2147483647);
            end else if (w_pr[a] < -64'sd2147483647) begin
                w_pos[a] = -PSW'(2147483647);
            end else begin
                w_pos[a] = PSW'(w_pr[a]);
            end
        end
    end

    assign w_ok = (r3_tag.side.status == uvs_pkg::ST_OK);

    uvs_pkg::t_status       r_out_status;
    logic [VW-1:0]          r_out_vidx;
    logic [VW-1:0]          r_out_second;
    logic                   r_out_faces;
    logic [TXW-1:0]         r_out_tex_u;
    logic [TXW-1:0]         r_out_tex_v;
    logic signed [PSW-1:0]  r_out_pos [3];
    logic signed [NW-1:0]   r_out_norm [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_status <= r3_tag.side.status;
            r_out_vidx   <= w_ok ? r3_tag.side.vidx : '0;
            r_out_faces  <= w_ok && r3_tag.side.faces;
            r_out_second <= (w_ok && r3_tag.side.faces) ? r3_tag.side.second : '0;
            r_out_tex_u  <= w_ok ? r3_tag.tex_u : '0;
            r_out_tex_v  <= w_ok ? r3_tag.tex_v : '0;
            for (int a = 0; a < 3; a++) begin
                r_out_pos[a]  <= w_ok ? w_pos[a] : '0;
                r_out_norm[a] <= w_ok ? r3_norm[a] : '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b0, r_out_second, r_out_faces, r_out_tex_v, r_out_tex_u,
                            r_out_norm[2], r_out_norm[1], r_out_norm[0],
                            r_out_pos[2], r_out_pos[1], r_out_pos[0],
                            r_out_vidx, r_out_status};

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out_status != uvs_pkg::ST_OK
        |-> r_out_vidx == '0 && !r_out_faces && r_out_second == '0)
        else $error("error status with nonzero payload");

    a_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out_faces
        |-> r_out_second == r_out_vidx + VW'(r_seg) + VW'(1))
        else $error("second index mismatch");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out_status == uvs_pkg::ST_OK
        |-> r_out_tex_u <= TXW'(65536) && r_out_tex_v <= TXW'(65536))
        else $error("texture coordinate above one");
`endif

endmodule
`default_nettype wire
